// File: rtl/dsqirm_pkg.sv
// Shared constants and types for the dual sorted queue block.
`default_nettype none

package dsqirm_pkg;

    localparam int LIST_CAPACITY_DEF = 16;
    localparam int VALUE_W           = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Per-cell control from the list to one cell of its row.
    typedef struct packed {
        logic ins;       // insert transaction accepted for this list, list not full
        logic occupied;  // cell index below the fill count
        logic at_tail;   // cell index equals the fill count
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/dsqirm_cell.sv
// One cell of a sorted row: holds a byte and shifts right on an insert.
`default_nettype none

module dsqirm_cell
    import dsqirm_pkg::*;
(
    input  wire logic               clk,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [VALUE_W-1:0] value_in,
    input  wire logic               left_gt,
    input  wire logic [VALUE_W-1:0] left_value,
    output logic                    gt,
    output logic [VALUE_W-1:0]      cell_value
);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    assign gt         = ctrl.occupied && (value_reg > value_in);
    assign cell_value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (left_gt)
                value_next = left_value;
            else if (gt || ctrl.at_tail)
                value_next = value_in;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// File: rtl/dsqirm_list.sv
// One bounded ascending list: a row of cells plus its fill count.
`default_nettype none

module dsqirm_list
    import dsqirm_pkg::*;
#(
    parameter int CAPACITY = LIST_CAPACITY_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               op_en,
    input  wire logic               opcode,
    input  wire logic [VALUE_W-1:0] value,
    output logic [VALUE_W-1:0]      tail_value,
    output logic                    empty,
    output logic                    full
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic [CAPACITY-1:0]              gt_vec;
    logic [CAPACITY-1:0][VALUE_W-1:0] val_vec;
    cell_ctrl_t [CAPACITY-1:0]        ctrl_vec;

    logic do_ins;
    logic do_rem;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CW'(CAPACITY));
    assign do_ins = op_en && (opcode == OP_INSERT) && !full;
    assign do_rem = op_en && (opcode == OP_REMOVE) && !empty;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic               l_gt;
            logic [VALUE_W-1:0] l_val;

            assign ctrl_vec[i].ins      = do_ins;
            assign ctrl_vec[i].occupied = (CW'(i) < count_reg);
            assign ctrl_vec[i].at_tail  = (CW'(i) == count_reg);

            if (i == 0)
            begin : g_head
                assign l_gt  = 1'b0;
                assign l_val = '0;
            end
            else
            begin : g_body
                assign l_gt  = gt_vec[i-1];
                assign l_val = val_vec[i-1];
            end

            dsqirm_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl_vec[i]),
                .value_in   (value),
                .left_gt    (l_gt),
                .left_value (l_val),
                .gt         (gt_vec[i]),
                .cell_value (val_vec[i])
            );
        end
    endgenerate

    // Largest value sits in the cell just below the fill count.
    always_comb
    begin
        tail_value = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (CW'(k + 1) == count_reg)
                tail_value = tail_value | val_vec[k];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + CW'(1);
        else if (do_rem)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

`default_nettype wire

// File: rtl/dual_sorted_queue_insert_remove_max_core.sv
// Top level: two sorted lists of bytes with insert and remove-largest transactions.
// The result is registered and appears in the cycle after the input transaction is accepted.
// Throughput: one transaction per cycle unless the input stalls; each list row updates all its cells together.
// Input stalls only while a result waits and the output side stalls.
// Reset (rst_n, async, active low) empties both lists and drops any pending result;
// cell contents are not cleared.
`default_nettype none

module dual_sorted_queue_insert_remove_max_core
    import dsqirm_pkg::*;
#(
    parameter int LIST_CAPACITY = LIST_CAPACITY_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               opcode,
    input  wire logic               list_select,
    input  wire logic [VALUE_W-1:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [VALUE_W-1:0]      removed_value,
    output logic                    was_empty,
    output logic                    was_full
);

    logic               accept;
    logic [1:0]         op_en;
    logic [1:0][VALUE_W-1:0] tail_value;
    logic [1:0]         empty;
    logic [1:0]         full;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VALUE_W-1:0] removed_reg;
    logic               empty_reg;
    logic               full_reg;
    logic [VALUE_W-1:0] removed_next;
    logic               empty_next;
    logic               full_next;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign op_en[0] = accept && !list_select;
    assign op_en[1] = accept && list_select;

    genvar j;
    generate
        for (j = 0; j < 2; j++)
        begin : g_list
            dsqirm_list #(
                .CAPACITY (LIST_CAPACITY)
            ) u_list (
                .clk        (clk),
                .rst_n      (rst_n),
                .op_en      (op_en[j]),
                .opcode     (opcode),
                .value      (value),
                .tail_value (tail_value[j]),
                .empty      (empty[j]),
                .full       (full[j])
            );
        end
    endgenerate

    always_comb
    begin
        removed_next = '0;
        empty_next   = 1'b0;
        full_next    = 1'b0;
        if (opcode == OP_REMOVE)
        begin
            if (empty[list_select])
                empty_next = 1'b1;
            else
                removed_next = tail_value[list_select];
        end
        else
        begin
            full_next = full[list_select];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_reg <= removed_next;
            empty_reg   <= empty_next;
            full_reg    <= full_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_reg;
    assign was_empty     = empty_reg;
    assign was_full      = full_reg;

endmodule

`default_nettype wire

// File: bench/tb_dual_sorted_queue_insert_remove_max_core.sv
// Testbench for the dual sorted byte list block: random and directed traffic, scoreboard check.
`default_nettype none

module tb_dual_sorted_queue_insert_remove_max_core;
    import dsqirm_pkg::*;

    localparam int LIST_CAP    = LIST_CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_LEN    = 150;
    localparam int MAX_REPORTS = 60;

    localparam logic FIRST_LIST  = 1'b0;
    localparam logic SECOND_LIST = 1'b1;

    // traffic shaping per block of items
    localparam logic [1:0] PH_BUSY       = 2'd0;
    localparam logic [1:0] PH_SEND_IDLE  = 2'd1;
    localparam logic [1:0] PH_RECV_STALL = 2'd2;
    localparam logic [1:0] PH_BOTH       = 2'd3;

    typedef struct {
        logic               op;
        logic               sel;
        logic [VALUE_W-1:0] val;
        logic [1:0]         phase;
        bit                 drain_first;
    } list_op_t;

    typedef struct {
        logic [VALUE_W-1:0] removed;
        logic               empty;
        logic               full;
    } outcome_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               opcode = OP_INSERT;
    logic               list_select = FIRST_LIST;
    logic [VALUE_W-1:0] value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [VALUE_W-1:0] removed_value;
    logic               was_empty;
    logic               was_full;

    list_op_t    pending_ops[$];
    outcome_t    predicted_outcomes[$];
    logic [1:0]  phase = PH_BUSY;
    int          sent_count = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    // shadow copy of both lists
    logic [VALUE_W-1:0] shadow_list [2][LIST_CAP];
    int unsigned        shadow_count [2];

    dual_sorted_queue_insert_remove_max_core #(
        .LIST_CAPACITY(LIST_CAP)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .list_select(list_select),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .removed_value(removed_value),
        .was_empty(was_empty),
        .was_full(was_full)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic outcome_t apply_list_op(input logic op, input logic sel,
                                               input logic [VALUE_W-1:0] v);
        outcome_t    r;
        int unsigned pos;
        int          idx;
        r.removed = '0;
        r.empty   = 1'b0;
        r.full    = 1'b0;
        idx = sel;
        if (op == OP_INSERT)
        begin
            if (shadow_count[idx] >= LIST_CAP)
                r.full = 1'b1;
            else
            begin
                pos = shadow_count[idx];
                while (pos > 0 && shadow_list[idx][pos-1] > v)
                begin
                    shadow_list[idx][pos] = shadow_list[idx][pos-1];
                    pos--;
                end
                shadow_list[idx][pos] = v;
                shadow_count[idx]++;
            end
        end
        else if (shadow_count[idx] == 0)
            r.empty = 1'b1;
        else
        begin
            shadow_count[idx]--;
            r.removed = shadow_list[idx][shadow_count[idx]];
        end
        return r;
    endfunction

    task automatic add_op(input logic op, input logic sel, input logic [VALUE_W-1:0] v,
                          input logic [1:0] ph, input bit drain);
        list_op_t t;
        t.op          = op;
        t.sel         = sel;
        t.val         = v;
        t.phase       = ph;
        t.drain_first = drain;
        pending_ops.push_back(t);
    endtask

    task automatic report_mismatch(input string what, input int exp_v, input int act_v);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s expected %0d actual %0d", $time, what, exp_v, act_v);
    endtask

    // driver
    always @(posedge clk)
    begin : driver
        list_op_t nxt;
        bit       offer;
        int       idle_pct;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted_outcomes.push_back(apply_list_op(opcode, list_select, value));
                sent_count <= sent_count + 1;
            end
            if (!in_valid || !in_stall)
            begin
                offer = 1'b0;
                if (pending_ops.size() > 0)
                begin
                    offer = 1'b1;
                    idle_pct = (pending_ops[0].phase == PH_SEND_IDLE) ? 62 :
                               (pending_ops[0].phase == PH_BOTH) ? 33 : 0;
                    // a drain point holds the next transaction until all results are back
                    if (pending_ops[0].drain_first && predicted_outcomes.size() != 0)
                        offer = 1'b0;
                    else if ($urandom_range(99) < idle_pct)
                        offer = 1'b0;
                end
                if (offer)
                begin
                    nxt = pending_ops.pop_front();
                    in_valid    <= 1'b1;
                    opcode      <= nxt.op;
                    list_select <= nxt.sel;
                    value       <= nxt.val;
                    phase       <= nxt.phase;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && sent_count >= HOLD_AT)
            begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (phase == PH_RECV_STALL)
                out_stall <= ($urandom_range(99) < 62);
            else if (phase == PH_BOTH)
                out_stall <= ($urandom_range(99) < 33);
            else
                out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        outcome_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_outcomes.size() == 0)
                report_mismatch("unexpected result, removed_value", -1, removed_value);
            else
            begin
                e = predicted_outcomes.pop_front();
                if (removed_value !== e.removed)
                    report_mismatch("removed_value", e.removed, removed_value);
                if (was_empty !== e.empty)
                    report_mismatch("was_empty", e.empty, was_empty);
                if (was_full !== e.full)
                    report_mismatch("was_full", e.full, was_full);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [1:0]         ph;
        logic               op;
        logic [VALUE_W-1:0] v;
        int                 ins_bias;
        int                 val_mode;

        // first list: extremes, middle placement, drain, then empty removal
        add_op(OP_INSERT, FIRST_LIST, 8'd0, PH_BUSY, 1'b0);
        add_op(OP_INSERT, FIRST_LIST, 8'd255, PH_BUSY, 1'b0);
        add_op(OP_INSERT, FIRST_LIST, 8'd128, PH_BUSY, 1'b0);
        repeat (4)
            add_op(OP_REMOVE, FIRST_LIST, 8'($urandom_range(255)), PH_BUSY, 1'b0);
        add_op(OP_REMOVE, SECOND_LIST, 8'($urandom_range(255)), PH_BUSY, 1'b0);
        // second list: fill with duplicates and out-of-order values, then overflow
        add_op(OP_INSERT, SECOND_LIST, 8'd200, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd100, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd100, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd255, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd0, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd50, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd255, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd3, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd3, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd7, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd128, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd64, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd1, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd254, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd100, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd0, PH_BUSY, 1'b0);
        add_op(OP_INSERT, SECOND_LIST, 8'd9, PH_BUSY, 1'b0);
        add_op(OP_REMOVE, SECOND_LIST, 8'($urandom_range(255)), PH_BUSY, 1'b0);

        // random blocks; insert bias swings so both lists hit full and empty
        for (int blk = 0; blk < 35; blk++)
        begin
            ph = 2'(blk % 4);
            case ($urandom_range(3))
                0: ins_bias = 15;
                1: ins_bias = 50;
                2: ins_bias = 85;
                default: ins_bias = 97;
            endcase
            val_mode = $urandom_range(2);
            for (int k = 0; k < 50; k++)
            begin
                op = ($urandom_range(99) < ins_bias) ? OP_INSERT : OP_REMOVE;
                case (val_mode)
                    0: v = 8'($urandom_range(255));
                    1: v = $urandom_range(1) ? 8'($urandom_range(3))
                                             : 8'(252 + $urandom_range(3));
                    default: v = $urandom_range(1) ? 8'd255 : 8'd0;
                endcase
                add_op(op, 1'($urandom_range(1)), v, ph,
                       (k == 0 && blk % 4 == 0 && blk > 0));
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_valid || predicted_outcomes.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/dsqirm_pkg.sv
rtl/dsqirm_cell.sv
rtl/dsqirm_list.sv
rtl/dual_sorted_queue_insert_remove_max_core.sv
bench/tb_dual_sorted_queue_insert_remove_max_core.sv
